FILE: rtl/prba_pkg.sv
// Shared types and codes for the page run bitmap allocator
`timescale 1ns / 1ps
`default_nettype none
package prba_pkg;

  // pages held in one word of the used-page bitmap
  localparam int unsigned MapWordBits = 8;
  localparam int unsigned MapBitIdxW  = 3;

  // request field widths
  localparam int unsigned BytesW  = 24;
  localparam int unsigned FPageW  = 12;
  localparam int unsigned HdrW    = 7;
  localparam int unsigned SmallW  = 13;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 13;
  localparam int unsigned SumW    = 25;

  // configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 13;
  localparam logic [CfgIdxW-1:0] REG_HEADER = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_SMALL  = 1'b1;
  localparam logic [HdrW-1:0]    HDR_RESET   = 7'd16;
  localparam logic [SmallW-1:0]  SMALL_RESET = 13'd1024;

  // opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // result status codes
  localparam logic [StatusW-1:0] ST_OK       = 2'd0;
  localparam logic [StatusW-1:0] ST_NO_SPACE = 2'd1;
  localparam logic [StatusW-1:0] ST_SMALL    = 2'd2;
  localparam logic [StatusW-1:0] ST_BAD_FREE = 2'd3;

  // bitmap read address select
  localparam logic [1:0] RD_HOLD  = 2'd0;
  localparam logic [1:0] RD_ZERO  = 2'd1;
  localparam logic [1:0] RD_START = 2'd2;
  localparam logic [1:0] RD_NEXT  = 2'd3;

  // commands from controller to datapath
  typedef struct packed {
    logic               clr;
    logic               load;
    logic               dec_alloc;
    logic               dec_free;
    logic               scan;
    logic               mprep;
    logic               mark;
    logic               finish;
    logic [StatusW-1:0] fin_status;
    logic [1:0]         rd_sel;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic clr_last;
    logic opcode;
    logic is_small;
    logic too_big;
    logic bad_free;
    logic found;
    logic scan_last;
    logic mark_last;
  } stat_t;

endpackage
`default_nettype wire

FILE: rtl/page_run_bitmap_allocator.sv
// Top level: first-fit page allocator with used-page bitmap and run table
// Allocate: bitmap words are scanned from word 0 onward
//   (8 pages per word, one word per cycle), then the words of the run are marked;
//   small or too large requests, or no room after a full scan, end without marking.
// Free: run words are unmarked, a bad free ends early; one transaction in flight,
//   bound by the bitmap port. After reset a clearing pass holds busy high.
// Results show for one cycle on done_o; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module page_run_bitmap_allocator #(
  parameter int unsigned PAGE_COUNT = 4096,
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              start,
  output logic                             busy,
  input  wire                              cfg_we_i,
  input  wire  [prba_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire  [prba_pkg::CfgDataW-1:0]    cfg_data_i,
  input  wire                              opcode_i,
  input  wire  [prba_pkg::BytesW-1:0]      request_bytes_i,
  input  wire  [prba_pkg::FPageW-1:0]      free_page_i,
  output logic                             done_o,
  output logic [prba_pkg::StatusW-1:0]     status_o,
  output logic [prba_pkg::FPageW-1:0]      page_start_o,
  output logic [prba_pkg::BytesW-1:0]      byte_offset_o,
  output logic [prba_pkg::CountW-1:0]      page_count_o
);
  import prba_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // controller
  prba_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy),
    .done_o (done_o)
  );

  // datapath
  prba_datapath #(
    .PAGE_COUNT (PAGE_COUNT),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .opcode_i        (opcode_i),
    .request_bytes_i (request_bytes_i),
    .free_page_i     (free_page_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .status_o        (status_o),
    .page_start_o    (page_start_o),
    .byte_offset_o   (byte_offset_o),
    .page_count_o    (page_count_o)
  );

  // a result strobe is always followed by done_o low
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held");

  // an accepted transaction makes the block busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("busy not raised");

  // failed allocations carry empty fields
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_SMALL || status_o == ST_NO_SPACE)) |->
      (page_start_o == '0 && byte_offset_o == '0 && page_count_o == '0))
    else $error("failed allocation has nonzero fields");

  // a result only appears while the block is idle again
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result while busy");

endmodule
`default_nettype wire

FILE: rtl/prba_datapath.sv
// Datapath: bitmap and run table memories, search, run marking, results
`timescale 1ns / 1ps
`default_nettype none
module prba_datapath #(
  parameter int unsigned PAGE_COUNT = 4096,
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [prba_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire  [prba_pkg::CfgDataW-1:0]    cfg_data_i,
  input  wire                              opcode_i,
  input  wire  [prba_pkg::BytesW-1:0]      request_bytes_i,
  input  wire  [prba_pkg::FPageW-1:0]      free_page_i,
  input  prba_pkg::cmd_t                   cmd_i,
  output prba_pkg::stat_t                  stat_o,
  output logic [prba_pkg::StatusW-1:0]     status_o,
  output logic [prba_pkg::FPageW-1:0]      page_start_o,
  output logic [prba_pkg::BytesW-1:0]      byte_offset_o,
  output logic [prba_pkg::CountW-1:0]      page_count_o
);
  import prba_pkg::*;

  localparam int unsigned PW  = $clog2(PAGE_COUNT);
  localparam int unsigned CW  = $clog2(PAGE_COUNT + 1);
  localparam int unsigned NW  = (PAGE_COUNT + MapWordBits - 1) / MapWordBits;
  localparam int unsigned AW  = (NW > 1) ? $clog2(NW) : 1;
  localparam int unsigned PGW = SumW - PAGE_SHIFT;
  localparam int unsigned RoundAdd = (1 << PAGE_SHIFT) - 1;

  // memories
  logic [MapWordBits-1:0] map_mem [NW];
  logic [CW-1:0]          tbl_mem [PAGE_COUNT];

  logic [MapWordBits-1:0] map_rd_q;
  logic [CW-1:0]          tbl_rd_q;

  // configuration registers
  logic [HdrW-1:0]   hdr_q;
  logic [SmallW-1:0] small_q;

  // clearing pass counter
  logic [PW-1:0] clr_q;

  // captured transaction
  logic              op_q;
  logic [BytesW-1:0] bytes_q;
  logic [FPageW-1:0] fpage_q;
  logic [PGW-1:0]    pages_q;

  // run state
  logic [CW-1:0] n_q;
  logic [PW-1:0] s_q;
  logic [PW-1:0] e_q;
  logic [AW-1:0] a_q;
  logic [CW-1:0] r_q;
  logic [PW-1:0] rs_q;

  // combinational helpers
  logic [AW-1:0]          map_raddr;
  logic [AW-1:0]          s_word;
  logic [AW-1:0]          e_word;
  logic [SumW-1:0]        sum;
  logic [31:0]            fp32;
  logic [31:0]            fend32;
  logic [CW-1:0]          r_d;
  logic [PW-1:0]          rs_d;
  logic                   found;
  logic [PW-1:0]          fs;
  logic [PW-1:0]          fe;
  logic [MapWordBits-1:0] mask;
  logic [MapWordBits-1:0] map_wdata;
  logic [31:0]            pg;
  logic [31:0]            pg_m;

  assign s_word = AW'(s_q >> MapBitIdxW);
  assign e_word = AW'(e_q >> MapBitIdxW);
  assign fp32   = 32'(fpage_q);
  assign fend32 = fp32 + 32'(tbl_rd_q) - 32'd1;
  assign sum    = SumW'(request_bytes_i) + SumW'(hdr_q) + SumW'(RoundAdd);

  // bitmap read address
  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_ZERO:  map_raddr = '0;
      RD_START: map_raddr = s_word;
      RD_NEXT:  map_raddr = a_q + AW'(1);
      default:  map_raddr = a_q;
    endcase
  end

  // first-fit scan of one bitmap word
  always_comb begin
    r_d   = r_q;
    rs_d  = rs_q;
    found = 1'b0;
    fs    = '0;
    fe    = '0;
    pg    = '0;
    for (int j = 0; j < MapWordBits; j++) begin
      pg = 32'(a_q) * MapWordBits + 32'(j);
      if (!found) begin
        if (map_rd_q[j] || (pg >= 32'(PAGE_COUNT))) begin
          r_d  = '0;
          rs_d = PW'(pg + 32'd1);
        end else begin
          r_d = r_d + CW'(1);
          if (r_d == n_q) begin
            found = 1'b1;
            fs    = rs_d;
            fe    = PW'(pg);
          end
        end
      end
    end
  end

  // run mask for the current word
  always_comb begin
    pg_m = '0;
    for (int j = 0; j < MapWordBits; j++) begin
      pg_m    = 32'(a_q) * MapWordBits + 32'(j);
      mask[j] = (pg_m >= 32'(s_q)) && (pg_m <= 32'(e_q));
    end
  end

  assign map_wdata = (op_q == OP_ALLOC) ? (map_rd_q | mask) : (map_rd_q & ~mask);

  // bitmap memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr && (32'(clr_q) < 32'(NW))) begin
      map_mem[AW'(clr_q)] <= '0;
    end else if (cmd_i.mark) begin
      map_mem[a_q] <= map_wdata;
    end
    map_rd_q <= map_mem[map_raddr];
  end

  // run table memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      tbl_mem[clr_q] <= '0;
    end else if (cmd_i.mprep) begin
      tbl_mem[s_q] <= (op_q == OP_ALLOC) ? n_q : '0;
    end
    tbl_rd_q <= tbl_mem[PW'(32'(free_page_i))];
  end

  // configuration and clearing counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q   <= HDR_RESET;
      small_q <= SMALL_RESET;
      clr_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_HEADER: hdr_q   <= HdrW'(cfg_data_i);
          REG_SMALL:  small_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.clr) begin
        clr_q <= clr_q + PW'(1);
      end
    end
  end

  // transaction capture, search and run registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= opcode_i;
      bytes_q <= request_bytes_i;
      fpage_q <= free_page_i;
      pages_q <= PGW'(sum >> PAGE_SHIFT);
    end
    if (cmd_i.dec_alloc) begin
      n_q  <= CW'(pages_q);
      r_q  <= '0;
      rs_q <= '0;
      a_q  <= '0;
    end
    if (cmd_i.dec_free) begin
      n_q <= tbl_rd_q;
      s_q <= PW'(fp32);
      e_q <= PW'(fend32);
    end
    if (cmd_i.scan) begin
      r_q  <= r_d;
      rs_q <= rs_d;
      a_q  <= a_q + AW'(1);
      if (found) begin
        s_q <= fs;
        e_q <= fe;
      end
    end
    if (cmd_i.mprep) begin
      a_q <= s_word;
    end
    if (cmd_i.mark) begin
      a_q <= a_q + AW'(1);
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      status_o <= cmd_i.fin_status;
      unique case (cmd_i.fin_status)
        ST_OK: begin
          page_start_o  <= FPageW'(s_q);
          byte_offset_o <= BytesW'({s_q, {PAGE_SHIFT{1'b0}}}) + BytesW'(hdr_q);
          page_count_o  <= CountW'(n_q);
        end
        ST_BAD_FREE: begin
          page_start_o  <= fpage_q;
          byte_offset_o <= '0;
          page_count_o  <= '0;
        end
        default: begin
          page_start_o  <= '0;
          byte_offset_o <= '0;
          page_count_o  <= '0;
        end
      endcase
    end
  end

  // status to the controller
  always_comb begin
    stat_o.clr_last  = (clr_q == PW'(PAGE_COUNT - 1));
    stat_o.opcode    = op_q;
    stat_o.is_small  = ({11'd0, small_q} >= bytes_q);
    stat_o.too_big   = (32'(pages_q) > 32'(PAGE_COUNT));
    stat_o.bad_free  = (fp32 >= 32'(PAGE_COUNT)) || (tbl_rd_q == '0);
    stat_o.found     = found;
    stat_o.scan_last = (a_q == AW'(NW - 1));
    stat_o.mark_last = (a_q == e_word);
  end

endmodule
`default_nettype wire

FILE: rtl/prba_ctrl.sv
// Controller state machine for the page run bitmap allocator
`timescale 1ns / 1ps
`default_nettype none
module prba_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              start,
  input  prba_pkg::stat_t  stat_i,
  output prba_pkg::cmd_t   cmd_o,
  output logic             busy,
  output logic             done_o
);
  import prba_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DECODE = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_MPREP  = 3'd4;
  localparam logic [2:0] S_MARK   = 3'd5;

  logic [2:0] state_q, state_d;
  logic       done_q;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rd_sel = RD_HOLD;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat_i.opcode == OP_ALLOC) begin
          if (stat_i.is_small) begin
            cmd_o.finish     = 1'b1;
            cmd_o.fin_status = ST_SMALL;
            state_d          = S_IDLE;
          end else if (stat_i.too_big) begin
            cmd_o.finish     = 1'b1;
            cmd_o.fin_status = ST_NO_SPACE;
            state_d          = S_IDLE;
          end else begin
            cmd_o.dec_alloc = 1'b1;
            cmd_o.rd_sel    = RD_ZERO;
            state_d         = S_SCAN;
          end
        end else begin
          if (stat_i.bad_free) begin
            cmd_o.finish     = 1'b1;
            cmd_o.fin_status = ST_BAD_FREE;
            state_d          = S_IDLE;
          end else begin
            cmd_o.dec_free = 1'b1;
            state_d        = S_MPREP;
          end
        end
      end
      S_SCAN: begin
        cmd_o.scan   = 1'b1;
        cmd_o.rd_sel = RD_NEXT;
        if (stat_i.found) begin
          state_d = S_MPREP;
        end else if (stat_i.scan_last) begin
          cmd_o.finish     = 1'b1;
          cmd_o.fin_status = ST_NO_SPACE;
          state_d          = S_IDLE;
        end
      end
      S_MPREP: begin
        cmd_o.mprep  = 1'b1;
        cmd_o.rd_sel = RD_START;
        state_d      = S_MARK;
      end
      S_MARK: begin
        cmd_o.mark   = 1'b1;
        cmd_o.rd_sel = RD_NEXT;
        if (stat_i.mark_last) begin
          cmd_o.finish     = 1'b1;
          cmd_o.fin_status = ST_OK;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmd_o.finish;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule
`default_nettype wire
